FILE: design/flpte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpte_pkg
// Shared types and constants for the four-level page table engine.
// ----------------------------------------------------------------------------
package flpte_pkg;

    localparam int NUM_TABLES_DEF = 16;
    localparam int PN_W           = 40;
    localparam int IDX_W          = 9;
    localparam int ENTRY_W        = 64;

    localparam logic [1:0] OP_MAP_4K     = 2'd0;
    localparam logic [1:0] OP_MAP_2M     = 2'd1;
    localparam logic [1:0] OP_TRANSLATE  = 2'd2;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    localparam logic [63:0] F_PRESENT  = 64'h01;
    localparam logic [63:0] F_WRITABLE = 64'h02;
    localparam logic [63:0] F_HUGE     = 64'h80;

    typedef struct packed {
        logic present;
        logic huge;
        logic outside;
    } entry_info_t;

endpackage

FILE: design/flpte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpte_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module flpte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/flpte_follow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpte_follow
// Decodes a table entry and resolves its pointer to a pool table number.
// ----------------------------------------------------------------------------
module flpte_follow #(
    parameter int NUM_TABLES = flpte_pkg::NUM_TABLES_DEF
) (
    input  logic [flpte_pkg::ENTRY_W-1:0]      entry,
    input  logic [flpte_pkg::PN_W-1:0]         base,
    input  logic [$clog2(NUM_TABLES+1)-1:0]    used,
    output flpte_pkg::entry_info_t             info,
    output logic [$clog2(NUM_TABLES)-1:0]      tab
);
    import flpte_pkg::*;

    localparam int UW = $clog2(NUM_TABLES + 1);
    localparam int TW = $clog2(NUM_TABLES);

    logic [PN_W-1:0] k;

    assign k            = entry[51:12] - base;
    assign info.present = entry[0];
    assign info.huge    = entry[7];
    assign info.outside = (k >= {{(PN_W-UW){1'b0}}, used});
    assign tab          = k[TW-1:0];
endmodule

FILE: design/four_level_page_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_engine
// Maps 4 KiB and 2 MiB pages and translates addresses in a pool of tables.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         tuser: operation; tdata: virt_addr, phys_addr, entry_flags
// m_*      out        tuser: status; tdata: result_addr
// cfg_*    in         pool_base_page
//
// A word reads a table entry for each level it walks through the RAM read port
// (S_READ), evaluates it (S_EVAL) and finishes in S_FIN; a map word writes its
// leaf in S_LEAF, and each new table is cleared at one entry a cycle (S_CLEAR)
// and linked (S_LINK). After reset the root table is cleared before the first
// word is taken. A new word is taken only once the previous result has left the output register.
// ----------------------------------------------------------------------------
module four_level_page_table_engine #(
    parameter int NUM_TABLES = flpte_pkg::NUM_TABLES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [175:0]  s_tdata,   // virt_addr[47:0], phys_addr[111:48], entry_flags[175:112]
    input  logic [1:0]    s_tuser,   // operation[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // result_addr[63:0]
    output logic [1:0]    m_tuser,   // status[1:0]
    input  logic          cfg_wen,
    input  logic [39:0]   cfg_wdata
);
    import flpte_pkg::*;

    localparam int UW = $clog2(NUM_TABLES + 1);
    localparam int TW = $clog2(NUM_TABLES);
    localparam int AW = TW + IDX_W;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_LEAF  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [PN_W-1:0]  base_reg;
    logic [UW-1:0]    used_reg, used_next;
    logic [TW-1:0]    tab_reg, tab_next;
    logic [TW-1:0]    clr_tab_reg, clr_tab_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       level_reg, level_next;
    logic [1:0]       op_reg;
    logic [47:0]      va_reg;
    logic [63:0]      pa_reg;
    logic [63:0]      flags_reg;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [63:0]      out_addr_reg, out_addr_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [63:0]      mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [63:0]      mem_rdata;
    logic [IDX_W-1:0] idx;
    logic [PN_W-1:0]  link_page;
    logic             is_map;
    logic             is_huge;
    logic [1:0]       level_inc;
    logic [2:0]       after_step;
    entry_info_t      info;
    logic [TW-1:0]    follow_tab;
    logic             accept;

    flpte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TABLES * (2 ** IDX_W))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    flpte_follow #(
        .NUM_TABLES (NUM_TABLES)
    ) u_follow (
        .entry (mem_rdata),
        .base  (base_reg),
        .used  (used_reg),
        .info  (info),
        .tab   (follow_tab)
    );

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    assign is_map    = (op_reg == OP_MAP_4K) || (op_reg == OP_MAP_2M);
    assign is_huge   = (op_reg == OP_MAP_2M);
    assign level_inc = level_reg + 2'd1;
    assign link_page = base_reg + {{(PN_W-TW){1'b0}}, clr_tab_reg};

    always_comb
    begin
        unique case (level_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    always_comb
    begin
        if (is_map && ((is_huge && level_inc == 2'd2) || level_inc == 2'd3))
        begin
            after_step = S_LEAF;
        end
        else
        begin
            after_step = S_READ;
        end
    end

    assign mem_raddr = {tab_reg, idx};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {tab_reg, idx};
        mem_wdata = 64'd0;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {clr_tab_reg, cnt_reg};
            end
            S_LINK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {12'd0, link_page, 12'd0} | flags_reg | F_PRESENT | F_WRITABLE;
            end
            S_LEAF:
            begin
                mem_we    = 1'b1;
                mem_wdata = {pa_reg[63:12], 12'd0} | flags_reg | F_PRESENT
                            | (is_huge ? F_HUGE : 64'd0);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        tab_next        = tab_reg;
        clr_tab_next    = clr_tab_reg;
        cnt_next        = cnt_reg;
        level_next      = level_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    tab_next        = '0;
                    level_next      = 2'd0;
                    out_status_next = ST_OK;
                    out_addr_next   = 64'd0;
                    if (s_tuser == OP_UNUSED)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!is_map)
                begin
                    priority if (level_reg == 2'd2 && info.huge)
                    begin
                        out_addr_next = {mem_rdata[63:21], va_reg[20:0]};
                        state_next    = S_FIN;
                    end
                    else if (!info.present)
                    begin
                        out_status_next = ST_UNMAPPED;
                        state_next      = S_FIN;
                    end
                    else if (level_reg == 2'd3)
                    begin
                        out_addr_next = {12'd0, mem_rdata[51:12], va_reg[11:0]};
                        state_next    = S_FIN;
                    end
                    else if (info.outside)
                    begin
                        out_status_next = ST_OUTSIDE;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        tab_next   = follow_tab;
                        level_next = level_inc;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    priority if (info.present)
                    begin
                        if (info.outside)
                        begin
                            out_status_next = ST_OUTSIDE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            tab_next   = follow_tab;
                            level_next = level_inc;
                            state_next = after_step;
                        end
                    end
                    else if (used_reg == UW'(NUM_TABLES))
                    begin
                        out_status_next = ST_FULL;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        clr_tab_next = used_reg[TW-1:0];
                        used_next    = used_reg + 1'b1;
                        cnt_next     = '0;
                        state_next   = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                tab_next   = clr_tab_reg;
                level_next = level_inc;
                state_next = after_step;
            end
            S_LEAF:
            begin
                state_next = S_FIN;
            end
            default:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            base_reg       <= '0;
            used_reg       <= UW'(1);
            tab_reg        <= '0;
            clr_tab_reg    <= '0;
            cnt_reg        <= '0;
            level_reg      <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            tab_reg        <= tab_next;
            clr_tab_reg    <= clr_tab_next;
            cnt_reg        <= cnt_next;
            level_reg      <= level_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wen)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        if (accept)
        begin
            op_reg    <= s_tuser;
            va_reg    <= s_tdata[47:0];
            pa_reg    <= s_tdata[111:48];
            flags_reg <= s_tdata[175:112];
        end
    end
endmodule

FILE: design/flpte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flpte_checker
// Port-level checks on the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module flpte_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    import flpte_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a word is in progress");

    a_no_result_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("input taken while a result still waits");

    a_error_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == 64'd0))
        else $error("non-zero address with an error status");
endmodule

bind four_level_page_table_engine flpte_checker u_flpte_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level page table engine. A short table of
// directed words is followed by random map, translate and other traffic under
// three pool base settings. Fixed directed rows are checked against their own
// values, the rest against a behavioural model of the table walk alongside the stream.
// ----------------------------------------------------------------------------
module tb_top;
    import flpte_pkg::*;

    localparam int TABLES     = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  op;
        logic [47:0] va;
        logic [63:0] pa;
        logic [63:0] fl;
        bit          fixed;
        logic [1:0]  st;
        logic [63:0] ra;
    } dir_row_t;

    typedef struct {
        logic [1:0]  st;
        logic [63:0] ra;
    } walk_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wen;
    logic [39:0]  cfg_wdata;

    logic [63:0]  shadow_mem [TABLES*512];
    int           shadow_used;
    logic [39:0]  shadow_base;

    walk_result_t pending_q [$];
    logic [47:0]  mapped_va [$];
    int           errors;
    int           words_in;
    int           words_out;
    int           status_seen [4];
    int           idle_cycles;
    int           rx_mode;
    int           rx_left;
    logic         rx_hold;

    four_level_page_table_engine #(.NUM_TABLES(TABLES)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [1:0] follow_ptr(input logic [63:0] e, output int tab);
        logic [39:0] k;
        k = e[51:12] - shadow_base;
        tab = 0;
        if (k >= 40'(shadow_used))
            return ST_OUTSIDE;
        tab = int'(k);
        return ST_OK;
    endfunction

    function automatic logic [1:0] walk_alloc(input int parent, input logic [8:0] idx,
                                              input logic [63:0] fl, output int tab);
        int k;
        logic [39:0] pg;
        tab = 0;
        if (shadow_mem[parent*512 + idx][0])
            return follow_ptr(shadow_mem[parent*512 + idx], tab);
        if (shadow_used >= TABLES)
            return ST_FULL;
        k = shadow_used;
        shadow_used++;
        for (int i = 0; i < 512; i++)
            shadow_mem[k*512 + i] = 64'd0;
        pg = shadow_base + 40'(k);
        shadow_mem[parent*512 + idx] = {12'd0, pg, 12'd0} | fl | F_PRESENT | F_WRITABLE;
        tab = k;
        return ST_OK;
    endfunction

    function automatic walk_result_t predict_walk(input logic [1:0] op, input logic [47:0] va,
                                                  input logic [63:0] pa, input logic [63:0] fl);
        walk_result_t r;
        int t1;
        int t2;
        int t3;
        logic [63:0] e;
        r.st = ST_OK;
        r.ra = 64'd0;
        pa[11:0] = 12'd0;
        if (op == OP_MAP_4K || op == OP_MAP_2M)
        begin
            r.st = walk_alloc(0, va[47:39], fl, t1);
            if (r.st == ST_OK)
                r.st = walk_alloc(t1, va[38:30], fl, t2);
            if (r.st == ST_OK)
            begin
                if (op == OP_MAP_2M)
                    shadow_mem[t2*512 + va[29:21]] = pa | fl | F_PRESENT | F_HUGE;
                else
                begin
                    r.st = walk_alloc(t2, va[29:21], fl, t3);
                    if (r.st == ST_OK)
                        shadow_mem[t3*512 + va[20:12]] = pa | fl | F_PRESENT;
                end
            end
        end
        else if (op == OP_TRANSLATE)
        begin
            e = shadow_mem[va[47:39]];
            if (!e[0])
                return '{ST_UNMAPPED, 64'd0};
            r.st = follow_ptr(e, t1);
            if (r.st != ST_OK)
                return r;
            e = shadow_mem[t1*512 + va[38:30]];
            if (!e[0])
                return '{ST_UNMAPPED, 64'd0};
            r.st = follow_ptr(e, t1);
            if (r.st != ST_OK)
                return r;
            e = shadow_mem[t1*512 + va[29:21]];
            if (e[7])
                return '{ST_OK, {e[63:21], 21'd0} + {43'd0, va[20:0]}};
            if (!e[0])
                return '{ST_UNMAPPED, 64'd0};
            r.st = follow_ptr(e, t1);
            if (r.st != ST_OK)
                return r;
            e = shadow_mem[t1*512 + va[20:12]];
            if (!e[0])
                return '{ST_UNMAPPED, 64'd0};
            r.ra = {12'd0, e[51:12], 12'd0} + {52'd0, va[11:0]};
        end
        return r;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [47:0] va, input logic [63:0] pa,
                             input logic [63:0] fl, input bit fixed, input walk_result_t typed);
        walk_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {fl, pa, va};
        do @(posedge clk); while (!s_tready);
        r = predict_walk(op, va, pa, fl);
        pending_q.push_back(fixed ? typed : r);
        words_in++;
        if ((op == OP_MAP_4K || op == OP_MAP_2M) && mapped_va.size() < 256)
            mapped_va.push_back(va);
    endtask

    task automatic set_pool_base(input logic [39:0] v);
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (20) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen     <= 1'b0;
        shadow_base  = v;
    endtask

    function automatic logic [47:0] pick_va();
        logic [8:0] l4;
        logic [8:0] l3;
        case ($urandom_range(0, 3))
            0: l4 = 9'd0;
            1: l4 = 9'd1;
            2: l4 = 9'd3;
            default: l4 = 9'h1FF;
        endcase
        l3 = ($urandom_range(0, 4) == 0) ? 9'h1FF : 9'($urandom_range(0, 2));
        return {l4, l3, 9'($urandom_range(0, 5)), 9'($urandom), 12'($urandom)};
    endfunction

    task automatic random_phase(input int count);
        int burst;
        int gap;
        logic [1:0] op;
        logic [47:0] va;
        logic [63:0] pa;
        logic [63:0] fl;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            pa = {$urandom, $urandom};
            fl = ($urandom_range(0, 3) == 0) ? 64'(F_HUGE) : 64'(4 * $urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
            begin
                op = 2'($urandom);
                va = {16'($urandom), $urandom};
                fl = {$urandom, $urandom};
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                op = ($urandom_range(0, 2) == 0) ? OP_MAP_2M : OP_MAP_4K;
                va = pick_va();
            end
            else
            begin
                op = OP_TRANSLATE;
                if (mapped_va.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    va = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
                    va[11:0] = 12'($urandom);
                end
                else
                    va = pick_va();
            end
            send_word(op, va, pa, fl, 1'b0, '{ST_OK, 64'd0});
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    dir_row_t dir_rows [] = '{
        '{OP_TRANSLATE, 48'h0, 64'h0, 64'h0, 1, ST_UNMAPPED, 64'h0},
        '{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'h0, 64'h0, 1, ST_UNMAPPED, 64'h0},
        '{OP_UNUSED, 48'hFFFF_FFFF_FFFF, '1, '1, 1, ST_OK, 64'h0},
        '{OP_MAP_4K, 48'h1000, 64'hABCD_E123, 64'h0, 1, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'h1ABC, 64'h0, 64'h0, 0, ST_OK, 64'h0},
        '{OP_MAP_2M, 48'h4000_0000, 64'h1_2345_6789, 64'h0, 1, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'h4012_3456, 64'h0, 64'h0, 0, ST_OK, 64'h0},
        '{OP_MAP_4K, 48'h4000_5000, 64'h7000, 64'h0, 1, ST_OUTSIDE, 64'h0},
        '{OP_MAP_4K, 48'h0080_0000_0000, 64'h5000, 64'h80, 1, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'h0080_0000_0123, 64'h0, 64'h0, 0, ST_OK, 64'h0},
        '{OP_MAP_4K, 48'h0100_0000_0000, 64'h0, 64'h0000_0100_0000_0000, 1, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'h0100_0000_0000, 64'h0, 64'h0, 1, ST_OUTSIDE, 64'h0},
        '{OP_MAP_4K, 48'hFFFF_FFFF_F000, '1, '1, 1, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'h0, 64'h0, 1, ST_OUTSIDE, 64'h0},
        '{OP_MAP_4K, 48'h2000, '1, 64'h0, 1, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'h2FFF, 64'h0, 64'h0, 0, ST_OK, 64'h0},
        '{OP_TRANSLATE, 48'h3000, 64'h0, 64'h0, 1, ST_UNMAPPED, 64'h0},
        '{OP_TRANSLATE, 48'h4020_0000, 64'h0, 64'h0, 1, ST_UNMAPPED, 64'h0}
    };

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(5, 60);
        end
        else
            rx_left <= rx_left - 1;
        if (rx_hold)
            m_tready <= 1'b0;
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_mode == 1)
            m_tready <= 1'($urandom_range(0, 1));
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        rx_hold = 1'b0;
        wait (words_in >= 150);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        walk_result_t x;
        if (m_tvalid && m_tready)
        begin
            words_out++;
            status_seen[m_tuser]++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result status %0d addr %h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                x = pending_q.pop_front();
                if (m_tuser !== x.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, x.st, m_tuser);
                    errors++;
                end
                if (m_tdata !== x.ra)
                begin
                    $display("%0t: result_addr expected %h actual %h", $time, x.ra, m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wen     = 1'b0;
        cfg_wdata   = '0;
        m_tready    = 1'b0;
        rx_mode     = 0;
        rx_left     = 0;
        errors      = 0;
        words_in    = 0;
        words_out   = 0;
        idle_cycles = 0;
        status_seen = '{0, 0, 0, 0};
        shadow_used = 1;
        shadow_base = '0;
        foreach (shadow_mem[i])
            shadow_mem[i] = 64'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_pool_base(40'd0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].va, dir_rows[i].pa, dir_rows[i].fl,
                      dir_rows[i].fixed, '{dir_rows[i].st, dir_rows[i].ra});
        random_phase(650);
        set_pool_base(40'hFF_FFFF_FFFF);
        random_phase(300);
        set_pool_base({8'($urandom), $urandom});
        random_phase(300);
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("Covered %0d words in, %0d results out, three pool bases, %0d tables used.",
                 words_in, words_out, shadow_used);
        $display("Status counts: ok %0d, full %0d, unmapped %0d, outside %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: sim.f
design/flpte_pkg.sv
design/flpte_ram.sv
design/flpte_follow.sv
design/four_level_page_table_engine.sv
design/flpte_checker.sv
tb/tb_top.sv
